// File: design/priority_schedule_times_core_macros.svh
// ---------------------------------------------------------------------------
// priority_schedule_times_core_macros
// Assertion shorthands for the scheduler checker. All of them sample on
// i_clk and are disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULE_TIMES_CORE_MACROS_SVH
`define PRIORITY_SCHEDULE_TIMES_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/psched_pkg.sv
// ---------------------------------------------------------------------------
// psched_pkg
// Shared widths, defaults and transfer types of the priority scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psched_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam int BURST_W = 16;
    localparam int PRI_W   = 8;
    localparam int ID_W    = 5;
    localparam int TIME_W  = 20;
    localparam int AVG_W   = 28;
    localparam int WTOT_W  = 24;
    localparam int TTOT_W  = 25;
    localparam int FRAC_W  = 8;
    // Dividend of the average: the wider total shifted by the fraction bits.
    localparam int DIVD_W  = TTOT_W + FRAC_W;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRI_W-1:0]   priority_req;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] job_burst;
        logic [PRI_W-1:0]   job_priority;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [AVG_W-1:0]   avg_turnaround_q8;
        logic               final_res;
    } t_out_item;

endpackage

// File: design/psched_div.sv
// ---------------------------------------------------------------------------
// psched_div
// Two restoring dividers sharing one step counter; one quotient bit per
// cycle, busy for DIVD_W steps, o_done raised together with the final quotients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psched_div #(
    parameter int DIVR_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [psched_pkg::DIVD_W-1:0] i_dvd_wait,
    input  logic [psched_pkg::DIVD_W-1:0] i_dvd_tat,
    input  logic [DIVR_W-1:0]            i_divisor,
    output logic                         o_done,
    output logic [psched_pkg::DIVD_W-1:0] o_quot_wait,
    output logic [psched_pkg::DIVD_W-1:0] o_quot_tat
);

    localparam int DW     = psched_pkg::DIVD_W;
    localparam int STEP_W = $clog2(DW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVR_W-1:0] r_dvr;
    logic [DW-1:0]     r_qa;
    logic [DW-1:0]     r_qb;
    logic [DIVR_W-1:0] r_ra;
    logic [DIVR_W-1:0] r_rb;

    logic [DIVR_W:0]   n_sa;
    logic [DIVR_W:0]   n_sb;
    logic              n_ge_a;
    logic              n_ge_b;
    logic [DIVR_W:0]   n_da;
    logic [DIVR_W:0]   n_db;

    always_comb begin
        n_sa   = {r_ra, r_qa[DW-1]};
        n_sb   = {r_rb, r_qb[DW-1]};
        n_ge_a = n_sa >= {1'b0, r_dvr};
        n_ge_b = n_sb >= {1'b0, r_dvr};
        n_da   = n_sa - {1'b0, r_dvr};
        n_db   = n_sb - {1'b0, r_dvr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == STEP_W'(DW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvr  <= i_divisor;
                r_qa   <= i_dvd_wait;
                r_qb   <= i_dvd_tat;
                r_ra   <= '0;
                r_rb   <= '0;
            end else if (r_busy) begin
                // shift one dividend bit into each remainder, subtract when it fits
                r_ra <= n_ge_a ? n_da[DIVR_W-1:0] : n_sa[DIVR_W-1:0];
                r_rb <= n_ge_b ? n_db[DIVR_W-1:0] : n_sb[DIVR_W-1:0];
                r_qa <= {r_qa[DW-2:0], n_ge_a};
                r_qb <= {r_qb[DW-2:0], n_ge_b};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quot_wait = r_qa;
    assign o_quot_tat  = r_qb;

endmodule

// File: design/priority_schedule_times_core.sv
// ---------------------------------------------------------------------------
// priority_schedule_times_core
// Non-preemptive priority scheduler over a batch of up to MAX_PROCS jobs.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one job per transfer,
// one transfer per cycle while loading. Jobs beyond MAX_PROCS are dropped.
// A job with last set closes the batch; o_in_stall then stays high until the
// final result of the batch sits in the output register.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per
// job in ascending priority, ties in arrival order. Each result takes a
// selection pass over the job memory through its single read port. The
// final result also waits for the bit-serial averaging divider.
// A stall on the output holds the result register and the schedule waits.
// Reset empties the batch and the output register; job memory is not
// cleared, only entries written in the current batch are read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_schedule_times_core #(
    parameter int MAX_PROCS = psched_pkg::MAX_PROCS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  psched_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output psched_pkg::t_out_item o_out_data
);

    localparam int BURST_W = psched_pkg::BURST_W;
    localparam int PRI_W   = psched_pkg::PRI_W;
    localparam int TIME_W  = psched_pkg::TIME_W;
    localparam int AVG_W   = psched_pkg::AVG_W;
    localparam int WTOT_W  = psched_pkg::WTOT_W;
    localparam int TTOT_W  = psched_pkg::TTOT_W;
    localparam int FRAC_W  = psched_pkg::FRAC_W;
    localparam int DIVD_W  = psched_pkg::DIVD_W;
    localparam int IDX_W   = $clog2(MAX_PROCS);
    localparam int CNT_W   = $clog2(MAX_PROCS + 1);
    localparam int KEY_W   = PRI_W + IDX_W;
    localparam int ENT_W   = BURST_W + PRI_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_CALC,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_rank;
    logic [CNT_W-1:0]      r_addr;
    logic [IDX_W-1:0]      r_q_idx;
    logic                  r_q_vld;
    logic [ENT_W-1:0]      r_rd_data;
    logic                  r_prev_vld;
    logic [KEY_W-1:0]      r_prev_key;
    logic                  r_best_vld;
    logic [KEY_W-1:0]      r_best_key;
    logic [BURST_W-1:0]    r_best_burst;
    logic [TTOT_W-1:0]     r_elapsed;
    logic [WTOT_W-1:0]     r_wait_total;
    logic [TTOT_W-1:0]     r_tat_total;
    logic [TIME_W-1:0]     r_wt;
    logic [TIME_W-1:0]     r_tt;
    logic                  r_last_rank;
    logic                  r_div_start;
    logic                  r_out_valid;
    psched_pkg::t_out_item r_out_data;

    logic [ENT_W-1:0]      mem [MAX_PROCS];

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  out_free;
    logic                  emit;
    logic                  rd_en;
    logic [KEY_W-1:0]      q_key;
    logic                  take;
    logic                  is_last_rank;
    logic [TTOT_W-1:0]     n_tt;
    logic [IDX_W:0]        n_id_full;
    psched_pkg::t_out_item n_out;
    logic                  div_done;
    logic [DIVD_W-1:0]     quot_wait;
    logic [DIVD_W-1:0]     quot_tat;

    assign in_xfer  = i_in_valid && (r_state == S_LOAD);
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = (r_state == S_EMIT) && out_free;
    assign rd_en    = (r_state == S_SCAN) && (r_addr < r_count);

    // Sort key: priority first, arrival index breaks ties.
    assign q_key = {r_rd_data[PRI_W-1:0], r_q_idx};
    assign take  = r_q_vld && (!r_prev_vld || (q_key > r_prev_key))
                   && (!r_best_vld || (q_key < r_best_key));

    assign is_last_rank = (r_rank + CNT_W'(1)) == r_count;
    assign n_tt         = r_elapsed + TTOT_W'(r_best_burst);
    assign n_id_full    = {1'b0, r_best_key[IDX_W-1:0]} + 1'b1;

    always_comb begin
        n_out.job_id            = psched_pkg::ID_W'(n_id_full);
        n_out.job_burst         = r_best_burst;
        n_out.job_priority      = r_best_key[KEY_W-1:IDX_W];
        n_out.wait_time         = r_wt;
        n_out.turnaround_time   = r_tt;
        n_out.avg_wait_q8       = r_last_rank ? quot_wait[AVG_W-1:0] : '0;
        n_out.avg_turnaround_q8 = r_last_rank ? quot_tat[AVG_W-1:0] : '0;
        n_out.final_res         = r_last_rank;
    end

    // Job memory: written while loading, read once per cycle during a pass.
    always_ff @(posedge i_clk) begin
        if (in_xfer && (r_count < CNT_W'(MAX_PROCS))) begin
            mem[r_count[IDX_W-1:0]] <= {i_in_data.burst_time, i_in_data.priority_req};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_q_vld      <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_wait_total <= '0;
            r_tat_total  <= '0;
        end else begin
            r_div_start <= (r_state == S_CALC) && is_last_rank;
            r_q_vld     <= rd_en;
            if (rd_en) begin
                r_q_idx <= r_addr[IDX_W-1:0];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (r_count < CNT_W'(MAX_PROCS)) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_in_data.last) begin
                            r_state      <= S_SCAN;
                            r_rank       <= '0;
                            r_addr       <= '0;
                            r_prev_vld   <= 1'b0;
                            r_best_vld   <= 1'b0;
                            r_elapsed    <= '0;
                            r_wait_total <= '0;
                            r_tat_total  <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (take) begin
                        r_best_vld   <= 1'b1;
                        r_best_key   <= q_key;
                        r_best_burst <= r_rd_data[ENT_W-1:PRI_W];
                    end
                    // all reads issued and the last compare done
                    if (!rd_en && !r_q_vld) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_wt         <= r_elapsed[TIME_W-1:0];
                    r_tt         <= n_tt[TIME_W-1:0];
                    r_elapsed    <= n_tt;
                    r_wait_total <= r_wait_total + r_elapsed[WTOT_W-1:0];
                    r_tat_total  <= r_tat_total + n_tt;
                    r_last_rank  <= is_last_rank;
                    if (is_last_rank) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_data <= n_out;
                        if (r_last_rank) begin
                            r_state      <= S_LOAD;
                            r_count      <= '0;
                            r_wait_total <= '0;
                            r_tat_total  <= '0;
                        end else begin
                            // advance to the next rank above the one just sent
                            r_prev_key <= r_best_key;
                            r_prev_vld <= 1'b1;
                            r_best_vld <= 1'b0;
                            r_rank     <= r_rank + 1'b1;
                            r_addr     <= '0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    psched_div #(
        .DIVR_W(CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dvd_wait ({1'b0, r_wait_total, {FRAC_W{1'b0}}}),
        .i_dvd_tat  ({r_tat_total, {FRAC_W{1'b0}}}),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot_wait(quot_wait),
        .o_quot_tat (quot_tat)
    );

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/psched_chk.sv
// ---------------------------------------------------------------------------
// psched_chk
// Port-level checks of the priority scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_schedule_times_core_macros.svh"

module psched_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input psched_pkg::t_in_item  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input psched_pkg::t_out_item o_out_data
);

    // A stalled result stays valid and unchanged.
    `PST_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // The batch closes on a last job: no further job is taken right after it.
    `PST_ASSERT_NEXT(a_last_closes, i_in_valid && !o_in_stall && i_in_data.last, o_in_stall, "input open right after last job")

    // Turnaround is wait plus own burst.
    `PST_ASSERT_SAME(a_tat_sum, o_out_valid, o_out_data.turnaround_time == psched_pkg::TIME_W'(o_out_data.wait_time + o_out_data.job_burst), "turnaround mismatch")

    // Averages appear on the final result only.
    `PST_ASSERT_SAME(a_avg_final, o_out_valid && !o_out_data.final_res, (o_out_data.avg_wait_q8 == '0) && (o_out_data.avg_turnaround_q8 == '0), "average on non-final result")

endmodule

bind priority_schedule_times_core psched_chk u_psched_chk (.*);

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority scheduler core. Batches of jobs are
// driven over the valid/stall input channel, and each batch is scheduled by
// a behavioral predictor. The scoreboard orders jobs by priority, keeping
// ties in arrival order, and builds the wait, turnaround and Q8 averages.
// Every result taken from the output channel is compared field by field.
// The input idles and the output stalls at random, and batches overfill the job store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class sched_scoreboard;
    localparam int CAP = psched_pkg::MAX_PROCS_DEF;

    bit [15:0] burst_mem [CAP];
    bit [7:0]  pri_mem [CAP];
    int unsigned job_count;
    psched_pkg::t_out_item sched_q[$];
    int errors;

    function int pending();
        return sched_q.size();
    endfunction

    // Store one accepted job; on the closing job schedule the whole batch.
    function void note_job(psched_pkg::t_in_item job);
        int unsigned order [CAP];
        int unsigned n, i, j, k, idx;
        bit [63:0] elapsed, wt, tt, wait_sum, turn_sum;
        psched_pkg::t_out_item r;
        if (job_count < CAP) begin
            burst_mem[job_count] = job.burst_time;
            pri_mem[job_count] = job.priority_req;
            job_count++;
        end
        if (!job.last) return;
        n = job_count;
        // stable insertion sort: a later job never jumps an equal priority
        for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && pri_mem[order[j - 1]] > pri_mem[i]) begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = i;
        end
        elapsed = 0;
        wait_sum = 0;
        turn_sum = 0;
        for (k = 0; k < n; k++) begin
            idx = order[k];
            wt = elapsed;
            tt = wt + burst_mem[idx];
            wait_sum = (wait_sum + wt) & 64'hFF_FFFF;
            turn_sum = (turn_sum + tt) & 64'h1FF_FFFF;
            elapsed = tt;
            r = '0;
            r.job_id = 5'(idx + 1);
            r.job_burst = burst_mem[idx];
            r.job_priority = pri_mem[idx];
            r.wait_time = wt[19:0];
            r.turnaround_time = tt[19:0];
            if (k + 1 == n) begin
                r.avg_wait_q8 = 28'((wait_sum << 8) / n);
                r.avg_turnaround_q8 = 28'((turn_sum << 8) / n);
                r.final_res = 1'b1;
            end
            sched_q.push_back(r);
        end
        job_count = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
        errors++;
    endtask

    task check_result(psched_pkg::t_out_item got);
        psched_pkg::t_out_item want;
        if (sched_q.size() == 0) begin
            report("unexpected result job_id", 32'(got.job_id), 32'd0);
            return;
        end
        want = sched_q.pop_front();
        if (got.job_id !== want.job_id)
            report("job_id", 32'(got.job_id), 32'(want.job_id));
        if (got.job_burst !== want.job_burst)
            report("job_burst", 32'(got.job_burst), 32'(want.job_burst));
        if (got.job_priority !== want.job_priority)
            report("job_priority", 32'(got.job_priority), 32'(want.job_priority));
        if (got.wait_time !== want.wait_time)
            report("wait_time", 32'(got.wait_time), 32'(want.wait_time));
        if (got.turnaround_time !== want.turnaround_time)
            report("turnaround_time", 32'(got.turnaround_time),
                   32'(want.turnaround_time));
        if (got.avg_wait_q8 !== want.avg_wait_q8)
            report("avg_wait_q8", 32'(got.avg_wait_q8), 32'(want.avg_wait_q8));
        if (got.avg_turnaround_q8 !== want.avg_turnaround_q8)
            report("avg_turnaround_q8", 32'(got.avg_turnaround_q8),
                   32'(want.avg_turnaround_q8));
        if (got.final_res !== want.final_res)
            report("final_res", 32'(got.final_res), 32'(want.final_res));
    endtask
endclass

module tb_top;
    localparam int CAP = psched_pkg::MAX_PROCS_DEF;
    localparam int JOB_TARGET = 420;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    psched_pkg::t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    psched_pkg::t_out_item out_data;

    bit no_idle = 1'b0;
    int idle_cycles = 0;
    sched_scoreboard sb = new();

    priority_schedule_times_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    // Transfer monitor and watchdog.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
                sb.note_job(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result sink: draw a stall for each result, then take it.
    initial begin
        int hold;
        wait (rst_n);
        @(negedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_job(input logic [15:0] burst, input logic [7:0] pri,
                            input logic is_last);
        int gap;
        psched_pkg::t_in_item job;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        job.burst_time = burst;
        job.priority_req = pri;
        job.last = is_last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= job;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // Hold the input until every scheduled result has been taken.
    task automatic drain_schedule();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_burst();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int loaded, set_len, narrow, j;
        logic [7:0] pri;
        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // single job batch, all zero
        send_job(16'h0000, 8'h00, 1'b1);
        // extremes with priority ties on both ends
        send_job(16'hFFFF, 8'hFF, 1'b0);
        send_job(16'h0000, 8'h00, 1'b0);
        send_job(16'hFFFF, 8'h00, 1'b0);
        send_job(16'h0001, 8'hFF, 1'b1);
        // fill the store with maximum bursts; the closing job is dropped
        for (j = 0; j <= CAP; j++)
            send_job(16'hFFFF, 8'(j % 3), j == CAP);
        drain_schedule();

        loaded = 0;
        while (loaded < JOB_TARGET) begin
            if ($urandom_range(0, 4) == 0)
                no_idle = ~no_idle;
            case ($urandom_range(0, 9))
                0: set_len = $urandom_range(CAP + 1, CAP + 4);
                1, 2: set_len = $urandom_range(12, CAP);
                default: set_len = $urandom_range(1, 8);
            endcase
            narrow = $urandom_range(0, 1);
            for (j = 0; j < set_len; j++) begin
                pri = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom());
                if ($urandom_range(0, 15) == 0)
                    pri = 8'hFF;
                send_job(pick_burst(), pri, j == set_len - 1);
            end
            loaded += (set_len > CAP) ? CAP : set_len;
            if ($urandom_range(0, 7) == 0)
                drain_schedule();
        end
        drain_schedule();
        repeat (60) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
